[design/sensor_seek_drive_mixer_core_defines.svh]
// Assertion macros shared by the seek-and-drive mixer RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef SENSOR_SEEK_DRIVE_MIXER_CORE_DEFINES_SVH
`define SENSOR_SEEK_DRIVE_MIXER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// consequent must hold in the same cycle as the antecedent
`define SSDM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SSDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SSDM_ASSERT_SAME(lbl, ante, cons, msg)
`define SSDM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[design/ssdm_pkg.sv]
// Types and constants for the seek-and-drive mixer.
// No dependencies; imported by sensor_seek_drive_mixer_core.
package ssdm_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int SPEED_W  = 7;
    localparam int TURN_W   = 9;
    localparam int DIR_W    = 2;
    localparam int PROD_W   = 14;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    // motor direction codes
    localparam logic [DIR_W-1:0] DIR_OFF = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FWD = 2'd1;
    localparam logic [DIR_W-1:0] DIR_REV = 2'd2;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_SPEED     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_SPEED      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_SPEED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_TURN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_TURN      = 3'd5;

    // register reset values
    localparam logic [SAMPLE_W-1:0] RST_DETECT_THRESHOLD = 12'd3000;
    localparam logic [SPEED_W-1:0]  RST_ATTACK_SPEED     = 7'd80;
    localparam logic [SPEED_W-1:0]  RST_PIVOT_SPEED      = 7'd40;
    localparam logic [SPEED_W-1:0]  RST_SEARCH_SPEED     = 7'd40;
    localparam logic [TURN_W-1:0]   RST_PIVOT_TURN       = 9'd200;
    localparam logic [TURN_W-1:0]   RST_SEARCH_TURN      = 9'd300;

    // limits and range bounds
    localparam logic [SPEED_W-1:0] SPEED_MAX  = 7'd100;
    localparam logic [TURN_W-1:0]  TURN_MAX   = 9'd300;
    localparam logic [TURN_W-1:0]  TURN_FWD_TOP = 9'd100;
    localparam logic [TURN_W-1:0]  TURN_OFF_TOP = 9'd200;

    // divide by 100 as multiply by 5243 then shift right 19, exact below 10100
    localparam logic [12:0] DIV100_RECIP = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam int          DIV100_PROD_W = 27;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left_sample;
        logic [SAMPLE_W-1:0] right_sample;
    } in_word_t;

    typedef struct packed {
        logic               left_seen;
        logic               right_seen;
        logic [DIR_W-1:0]   motor_a_dir;
        logic [SPEED_W-1:0] motor_a_duty;
        logic [DIR_W-1:0]   motor_b_dir;
        logic [SPEED_W-1:0] motor_b_duty;
    } out_word_t;

endpackage

[design/sensor_seek_drive_mixer_core.sv]
// Seek-and-drive mixer: sensor samples in, two motor direction/duty pairs out.
// Depends on ssdm_pkg and sensor_seek_drive_mixer_core_defines.svh.
//
// Each input word (a left and a right sensor sample) gives one output word,
// and while the output is not stalled a new word can be taken on every cycle,
// so a steady stream runs at one word per cycle. The path is
// three register stages: the input register, a stage that holds the detect
// flags, the chosen speed and the speed-by-turn product, and the output
// register that holds the result after the divide by 100. Each stage moves
// forward whenever the one ahead of it is empty or draining, so a stalled
// output still lets the earlier stages fill. cfg_ready is always high. The user
// must write registers on the cfg port only while the block is idle (not enforced).
`include "sensor_seek_drive_mixer_core_defines.svh"

module sensor_seek_drive_mixer_core
    import ssdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_word_t              in_word,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_word_t             out_word,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    logic [SAMPLE_W-1:0] detect_threshold_reg;
    logic [SPEED_W-1:0]  attack_speed_reg;
    logic [SPEED_W-1:0]  pivot_speed_reg;
    logic [SPEED_W-1:0]  search_speed_reg;
    logic [TURN_W-1:0]   pivot_turn_reg;
    logic [TURN_W-1:0]   search_turn_reg;
    logic                search_positive_reg;
    logic                search_positive_next;

    // pipeline registers
    logic                s1_valid_reg;
    in_word_t            s1_word_reg;
    logic                s2_valid_reg;
    logic                s2_lseen_reg;
    logic                s2_rseen_reg;
    logic [SPEED_W-1:0]  s2_speed_reg;
    logic [PROD_W-1:0]   s2_product_reg;
    logic [DIR_W-1:0]    s2_inner_dir_reg;
    logic                s2_inner_is_b_reg;
    logic                out_valid_reg;
    out_word_t           out_word_reg;

    // handshake between stages
    logic out_ready;
    logic s2_ready;
    logic s1_ready;

    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_ready  = !s2_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_threshold_reg <= RST_DETECT_THRESHOLD;
            attack_speed_reg     <= RST_ATTACK_SPEED;
            pivot_speed_reg      <= RST_PIVOT_SPEED;
            search_speed_reg     <= RST_SEARCH_SPEED;
            pivot_turn_reg       <= RST_PIVOT_TURN;
            search_turn_reg      <= RST_SEARCH_TURN;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_DETECT_THRESHOLD: detect_threshold_reg <= cfg_data[SAMPLE_W-1:0];
                REG_ATTACK_SPEED:     attack_speed_reg     <= cfg_data[SPEED_W-1:0];
                REG_PIVOT_SPEED:      pivot_speed_reg      <= cfg_data[SPEED_W-1:0];
                REG_SEARCH_SPEED:     search_speed_reg     <= cfg_data[SPEED_W-1:0];
                REG_PIVOT_TURN:       pivot_turn_reg       <= cfg_data[TURN_W-1:0];
                REG_SEARCH_TURN:      search_turn_reg      <= cfg_data[TURN_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_word_reg <= in_word;
        end
    end

    // detection, speed and turn selection, product
    logic               lseen;
    logic               rseen;
    logic [SPEED_W-1:0] speed_raw;
    logic [SPEED_W-1:0] speed_sat;
    logic [TURN_W-1:0]  turn_raw;
    logic [TURN_W-1:0]  mag;
    logic               positive;
    logic [SPEED_W-1:0] range_off;
    logic [DIR_W-1:0]   inner_dir_next;
    logic [PROD_W-1:0]  product_next;
    logic               inner_is_b_next;

    assign lseen = s1_word_reg.left_sample  < detect_threshold_reg;
    assign rseen = s1_word_reg.right_sample < detect_threshold_reg;

    always_comb
    begin
        search_positive_next = search_positive_reg;
        priority if (lseen && rseen)
        begin
            speed_raw = attack_speed_reg;
            turn_raw  = '0;
            positive  = 1'b1;
        end
        else if (lseen)
        begin
            search_positive_next = 1'b1;
            speed_raw = pivot_speed_reg;
            turn_raw  = pivot_turn_reg;
            positive  = 1'b1;
        end
        else if (rseen)
        begin
            search_positive_next = 1'b0;
            speed_raw = pivot_speed_reg;
            turn_raw  = pivot_turn_reg;
            positive  = 1'b0;
        end
        else
        begin
            speed_raw = search_speed_reg;
            turn_raw  = search_turn_reg;
            positive  = search_positive_reg;
        end
    end

    assign speed_sat = (speed_raw > SPEED_MAX) ? SPEED_MAX : speed_raw;
    assign mag       = (turn_raw > TURN_MAX) ? TURN_MAX : turn_raw;

    // pick the range: offset into it and the inner motor direction
    always_comb
    begin
        if (mag <= TURN_FWD_TOP)
        begin
            range_off      = mag[SPEED_W-1:0];
            inner_dir_next = DIR_FWD;
        end
        else if (mag <= TURN_OFF_TOP)
        begin
            range_off      = SPEED_W'(mag - TURN_FWD_TOP);
            inner_dir_next = DIR_OFF;
        end
        else
        begin
            range_off      = SPEED_W'(mag - TURN_OFF_TOP);
            inner_dir_next = DIR_REV;
        end
    end

    assign product_next    = PROD_W'(speed_sat) * PROD_W'(range_off);
    assign inner_is_b_next = !(positive || (mag == '0));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg        <= 1'b0;
            search_positive_reg <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s2_ready && s1_valid_reg)
            begin
                search_positive_reg <= search_positive_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_lseen_reg      <= lseen;
            s2_rseen_reg      <= rseen;
            s2_speed_reg      <= speed_sat;
            s2_product_reg    <= product_next;
            s2_inner_dir_reg  <= inner_dir_next;
            s2_inner_is_b_reg <= inner_is_b_next;
        end
    end

    // divide by 100 and assign inner and outer motors
    logic [DIV100_PROD_W-1:0] recip_prod;
    logic [SPEED_W-1:0]       quotient;
    logic [SPEED_W-1:0]       inner_duty;
    out_word_t                out_word_next;

    assign recip_prod = DIV100_PROD_W'(s2_product_reg) * DIV100_PROD_W'(DIV100_RECIP);
    assign quotient   = recip_prod[DIV100_SHIFT +: SPEED_W];
    assign inner_duty = (s2_inner_dir_reg == DIR_FWD) ? (s2_speed_reg - quotient) : quotient;

    always_comb
    begin
        out_word_next.left_seen  = s2_lseen_reg;
        out_word_next.right_seen = s2_rseen_reg;
        if (s2_inner_is_b_reg)
        begin
            out_word_next.motor_a_dir  = DIR_FWD;
            out_word_next.motor_a_duty = s2_speed_reg;
            out_word_next.motor_b_dir  = s2_inner_dir_reg;
            out_word_next.motor_b_duty = inner_duty;
        end
        else
        begin
            out_word_next.motor_a_dir  = s2_inner_dir_reg;
            out_word_next.motor_a_duty = inner_duty;
            out_word_next.motor_b_dir  = DIR_FWD;
            out_word_next.motor_b_duty = s2_speed_reg;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg)
        begin
            out_word_reg <= out_word_next;
        end
    end

    // checks
    `SSDM_ASSERT_SAME(a_duty_in_range, out_valid_reg,
        (out_word_reg.motor_a_duty <= SPEED_MAX) && (out_word_reg.motor_b_duty <= SPEED_MAX),
        "motor duty above full scale")
    `SSDM_ASSERT_SAME(a_outer_forward, out_valid_reg,
        (out_word_reg.motor_a_dir == DIR_FWD) || (out_word_reg.motor_b_dir == DIR_FWD),
        "neither motor runs forward")
    `SSDM_ASSERT_SAME(a_attack_straight,
        out_valid_reg && out_word_reg.left_seen && out_word_reg.right_seen,
        (out_word_reg.motor_a_dir == DIR_FWD) && (out_word_reg.motor_b_dir == DIR_FWD)
            && (out_word_reg.motor_a_duty == out_word_reg.motor_b_duty),
        "attack word is not straight")
    `SSDM_ASSERT_NEXT(a_left_remembered, s1_valid_reg && s2_ready && lseen && !rseen,
        search_positive_reg, "left-only sighting not remembered")

endmodule

[test/seek_drive_checker.sv]
// Checker for the seek-and-drive mixer: follows the cfg, input and output channels,
// predicts each output word and compares it with what the block delivers.
// Depends on ssdm_pkg; instantiated beside the block by the testbench top.
module seek_drive_checker
    import ssdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  in_word_t              in_word,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  out_word_t             out_word,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    // register copies and the remembered search side
    logic [SAMPLE_W-1:0] threshold;
    logic [SPEED_W-1:0]  attack_spd;
    logic [SPEED_W-1:0]  pivot_spd;
    logic [SPEED_W-1:0]  search_spd;
    logic [TURN_W-1:0]   pivot_trn;
    logic [TURN_W-1:0]   search_trn;
    logic                search_pos;

    // drive words still owed by the block, oldest first
    out_word_t expected_drives[$];

    function automatic int clip(input int value, input int top);
        return (value > top) ? top : value;
    endfunction

    // inner motor of a turn: forward, off or reverse by magnitude range
    function automatic void inner_motor(input int spd, input int mag,
                                        output logic [DIR_W-1:0] dir,
                                        output logic [SPEED_W-1:0] duty);
        if (mag <= int'(TURN_FWD_TOP))
        begin
            dir  = DIR_FWD;
            duty = SPEED_W'(spd - (spd * mag) / 100);
        end
        else if (mag <= int'(TURN_OFF_TOP))
        begin
            dir  = DIR_OFF;
            duty = SPEED_W'((spd * (mag - int'(TURN_FWD_TOP))) / 100);
        end
        else
        begin
            dir  = DIR_REV;
            duty = SPEED_W'((spd * (mag - int'(TURN_OFF_TOP))) / 100);
        end
    endfunction

    // expected drive word for one pair of samples; updates the search side
    function automatic out_word_t drive_for_samples(input in_word_t w);
        logic             lseen;
        logic             rseen;
        logic             toward_pos;
        int               spd;
        int               mag;
        logic [DIR_W-1:0] in_dir;
        logic [SPEED_W-1:0] in_duty;
        out_word_t        r;
        lseen = (w.left_sample < threshold);
        rseen = (w.right_sample < threshold);
        if (lseen && rseen)
        begin
            spd        = clip(attack_spd, SPEED_MAX);
            mag        = 0;
            toward_pos = 1'b1;
        end
        else if (lseen)
        begin
            search_pos = 1'b1;
            spd        = clip(pivot_spd, SPEED_MAX);
            mag        = clip(pivot_trn, TURN_MAX);
            toward_pos = 1'b1;
        end
        else if (rseen)
        begin
            search_pos = 1'b0;
            spd        = clip(pivot_spd, SPEED_MAX);
            mag        = clip(pivot_trn, TURN_MAX);
            toward_pos = 1'b0;
        end
        else
        begin
            spd        = clip(search_spd, SPEED_MAX);
            mag        = clip(search_trn, TURN_MAX);
            toward_pos = search_pos;
        end
        inner_motor(spd, mag, in_dir, in_duty);
        r.left_seen  = lseen;
        r.right_seen = rseen;
        // motor a is inner for a positive or zero turn, motor b otherwise
        if (toward_pos || mag == 0)
        begin
            r.motor_a_dir  = in_dir;
            r.motor_a_duty = in_duty;
            r.motor_b_dir  = DIR_FWD;
            r.motor_b_duty = SPEED_W'(spd);
        end
        else
        begin
            r.motor_a_dir  = DIR_FWD;
            r.motor_a_duty = SPEED_W'(spd);
            r.motor_b_dir  = in_dir;
            r.motor_b_duty = in_duty;
        end
        return r;
    endfunction

    task automatic report_field(input string field, input int exp_val, input int act_val);
        $display("%0t: %s expected %0d, got %0d", $time, field, exp_val, act_val);
        errors++;
    endtask

    // compare one delivered word with the oldest prediction
    task automatic compare_drive(input out_word_t got);
        out_word_t want;
        if (expected_drives.size() == 0)
        begin
            $display("%0t: output word %h with nothing expected", $time, got);
            errors++;
        end
        else
        begin
            want = expected_drives.pop_front();
            if (got.left_seen !== want.left_seen)
                report_field("left_seen", want.left_seen, got.left_seen);
            if (got.right_seen !== want.right_seen)
                report_field("right_seen", want.right_seen, got.right_seen);
            if (got.motor_a_dir !== want.motor_a_dir)
                report_field("motor_a_dir", want.motor_a_dir, got.motor_a_dir);
            if (got.motor_a_duty !== want.motor_a_duty)
                report_field("motor_a_duty", want.motor_a_duty, got.motor_a_duty);
            if (got.motor_b_dir !== want.motor_b_dir)
                report_field("motor_b_dir", want.motor_b_dir, got.motor_b_dir);
            if (got.motor_b_duty !== want.motor_b_duty)
                report_field("motor_b_duty", want.motor_b_duty, got.motor_b_duty);
        end
    endtask

    initial
    begin
        errors  = 0;
        pending = 0;
    end

    // channel monitor: cfg writes, accepted inputs, delivered outputs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold  = RST_DETECT_THRESHOLD;
            attack_spd = RST_ATTACK_SPEED;
            pivot_spd  = RST_PIVOT_SPEED;
            search_spd = RST_SEARCH_SPEED;
            pivot_trn  = RST_PIVOT_TURN;
            search_trn = RST_SEARCH_TURN;
            search_pos = 1'b0;
            expected_drives.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DETECT_THRESHOLD: threshold  = cfg_data[SAMPLE_W-1:0];
                    REG_ATTACK_SPEED:     attack_spd = cfg_data[SPEED_W-1:0];
                    REG_PIVOT_SPEED:      pivot_spd  = cfg_data[SPEED_W-1:0];
                    REG_SEARCH_SPEED:     search_spd = cfg_data[SPEED_W-1:0];
                    REG_PIVOT_TURN:       pivot_trn  = cfg_data[TURN_W-1:0];
                    REG_SEARCH_TURN:      search_trn = cfg_data[TURN_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_drives.push_back(drive_for_samples(in_word));
            if (out_valid && !out_stall)
                compare_drive(out_word);
        end
        pending = expected_drives.size();
    end

endmodule

[test/testbench.sv]
// Top of the seek-and-drive mixer testbench: clock, reset, sample and cfg stimulus,
// output stalls and the verdict. Depends on ssdm_pkg, sensor_seek_drive_mixer_core
// and seek_drive_checker.
module testbench;
    import ssdm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASES      = 12;
    localparam int PHASE_WORDS = 113;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_word_t              in_word;
    logic                  out_valid;
    logic                  out_stall;
    out_word_t             out_word;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors;
    int pending;
    int cycles = 0;
    int in_idle_pct = 35;
    int out_idle_pct = 35;
    int cur_threshold = RST_DETECT_THRESHOLD;
    bit hold_armed = 1'b0;

    sensor_seek_drive_mixer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    seek_drive_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // output side: random stalls, plus one long hold-off once armed
    initial
    begin : receiver
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_armed && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < out_idle_pct);
        end
    end

    // offer one sample word; entered and left at a falling edge
    task automatic send_pair(input int left, input int right);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{left_sample: SAMPLE_W'(left), right_sample: SAMPLE_W'(right)};
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_regs(input int thr, input int atk, input int piv, input int srch,
                            input int pturn, input int sturn);
        write_reg(REG_DETECT_THRESHOLD, thr);
        write_reg(REG_ATTACK_SPEED, atk);
        write_reg(REG_PIVOT_SPEED, piv);
        write_reg(REG_SEARCH_SPEED, srch);
        write_reg(REG_PIVOT_TURN, pturn);
        write_reg(REG_SEARCH_TURN, sturn);
        cur_threshold = thr;
    endtask

    // stop offering and wait for every owed word to come out
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // sample below, above, near the threshold, or anywhere
    function automatic int pick_sample();
        int near;
        case ($urandom_range(3))
            0: return $urandom_range(4095);
            1: return (cur_threshold == 0) ? $urandom_range(4095)
                                           : $urandom_range(cur_threshold - 1);
            2: return $urandom_range(4095, cur_threshold);
            default:
            begin
                near = cur_threshold + $urandom_range(2) - 1;
                return (near < 0) ? 0 : ((near > 4095) ? 4095 : near);
            end
        endcase
    endfunction

    // speeds and turns mostly in range, sometimes above it to hit saturation
    function automatic int pick_speed();
        return ($urandom_range(7) == 0) ? $urandom_range(127, 101) : $urandom_range(100);
    endfunction

    function automatic int pick_turn();
        return ($urandom_range(7) == 0) ? $urandom_range(511, 301) : $urandom_range(300);
    endfunction

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_DETECT_THRESHOLD;
        cfg_data  = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: all four detect cases, search memory both ways, threshold edge
        send_pair(0, 0);
        send_pair(4095, 4095);
        send_pair(0, 4095);
        send_pair(4095, 4095);
        send_pair(4095, 0);
        send_pair(4095, 4095);
        send_pair(2999, 3000);
        send_pair(3000, 2999);
        send_pair(12'hAAA, 12'h555);
        send_pair(12'h555, 12'hAAA);
        drain();

        // zero threshold: nothing seen, full speed and full turn
        set_regs(0, 100, 100, 100, 300, 300);
        send_pair(0, 0);
        send_pair(4095, 0);
        send_pair(0, 4095);
        drain();

        // top threshold, registers above range saturate
        set_regs(4095, 127, 127, 127, 511, 511);
        send_pair(4094, 4094);
        send_pair(4094, 4095);
        send_pair(4095, 4095);
        send_pair(4095, 4094);
        send_pair(4095, 4095);
        drain();

        // zero speeds and turns
        set_regs(2048, 0, 0, 0, 0, 0);
        send_pair(100, 100);
        send_pair(100, 3000);
        send_pair(3000, 3000);
        drain();

        // range edges: off with duty at 101 and 150
        set_regs(2048, 100, 77, 63, 150, 101);
        send_pair(2047, 3000);
        send_pair(3000, 3000);
        send_pair(3000, 2047);
        send_pair(3000, 3000);
        drain();

        // random phases, each with fresh settings
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 5)
                set_regs(1, 100, 0, 100, 201, 200);
            else if (p == 9)
                set_regs(4095, 0, 100, 0, 300, 100);
            else
                set_regs($urandom_range(4095), pick_speed(), pick_speed(), pick_speed(),
                         pick_turn(), pick_turn());
            in_idle_pct  = (p == 3) ? 0 : 35;
            out_idle_pct = (p == 3) ? 0 : 35;
            if (p == 7)
            begin
                in_idle_pct = 0;
                hold_armed  = 1'b1;
            end
            for (int n = 0; n < PHASE_WORDS; n++)
                send_pair(pick_sample(), pick_sample());
            drain();
        end

        // let any stray word show up
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
